@@ hdl/olist_pkg.sv @@
// Package: shared types and constants for the ordered list engine.
package olist_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PUSH_MID   = 3'd4,
        OP_POP_MID    = 3'd5,
        OP_INSERT_AT  = 3'd6,
        OP_FILTER     = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_LEFT  = 2'd1,
        ACT_RIGHT = 2'd2,
        ACT_LOAD  = 2'd3
    } t_cell_act;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_FILT = 2'd2
    } t_state;

endpackage

@@ hdl/olist_in_if.sv @@
// Interface: operation channel carrying one list command per beat.
interface olist_in_if;
    logic                                valid;
    logic                                ready;
    logic [olist_pkg::OP_W-1:0]          op;
    logic signed [olist_pkg::DATA_W-1:0] value;
    logic [olist_pkg::POS_W-1:0]         position;
    logic signed [olist_pkg::DATA_W-1:0] threshold;

    modport source (output valid, op, value, position, threshold, input ready);
    modport sink   (input valid, op, value, position, threshold, output ready);
endinterface

@@ hdl/olist_out_if.sv @@
// Interface: result channel carrying one status beat per command.
interface olist_out_if;
    logic                                valid;
    logic                                ready;
    logic [olist_pkg::STATUS_W-1:0]      status;
    logic signed [olist_pkg::DATA_W-1:0] removed_value;
    logic [olist_pkg::ECOUNT_W-1:0]      entry_count;

    modport source (output valid, status, removed_value, entry_count, input ready);
    modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

@@ hdl/olist_cell.sv @@
// Cell: one list slot that holds, shifts from a neighbor, or loads a value.
module olist_cell (
    input  logic                                i_clk,
    input  olist_pkg::t_cell_act                i_act,
    input  logic signed [olist_pkg::DATA_W-1:0] i_left,
    input  logic signed [olist_pkg::DATA_W-1:0] i_right,
    input  logic signed [olist_pkg::DATA_W-1:0] i_load,
    output logic signed [olist_pkg::DATA_W-1:0] o_data
);

    logic signed [olist_pkg::DATA_W-1:0] r_data;
    logic signed [olist_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_act)
            olist_pkg::ACT_HOLD:  n_data = r_data;
            olist_pkg::ACT_LEFT:  n_data = i_left;
            olist_pkg::ACT_RIGHT: n_data = i_right;
            olist_pkg::ACT_LOAD:  n_data = i_load;
            default:              n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/ordered_list_engine_unit.sv @@
// Top level: ordered list engine built as a shifting row of entry cells.
//
//  channel | dir | payload                                  | beat when
//  i_in    | in  | op, value, position, threshold           | valid & ready
//  o_out   | out | status, removed_value, entry_count       | valid & ready
//
//  Push and pop first latch the command and its index, then shift the cell row.
//  Filter scans with one cell row shift per entry, then reports its result.
//  i_rst_n (synchronous) clears the entry count, FSM and output valid only.
//  A result waits in the output register; a waiting result stalls the next
//  command, which is still latched when idle; a filter scans but waits to report.
module ordered_list_engine_unit #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    olist_in_if.sink     i_in,
    olist_out_if.source  o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW = (CW > olist_pkg::POS_W + 1) ? CW : olist_pkg::POS_W + 1;

    olist_pkg::t_state                   r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [CW-1:0]                       r_rem, n_rem;
    logic [CW-1:0]                       r_kept, n_kept;
    olist_pkg::t_op                      r_op;
    logic signed [olist_pkg::DATA_W-1:0] r_val;
    logic signed [olist_pkg::DATA_W-1:0] r_thr;
    logic [IW-1:0]                       r_idx;

    logic                                r_out_valid, n_out_valid;
    olist_pkg::t_status                  r_status, n_status;
    logic signed [olist_pkg::DATA_W-1:0] r_removed, n_removed;

    logic signed [olist_pkg::DATA_W-1:0] w_data [DEPTH];
    olist_pkg::t_cell_act                w_act  [DEPTH];
    logic signed [olist_pkg::DATA_W-1:0] w_load;
    logic                                w_do_ins, w_do_rem, w_do_filt;
    logic                                w_keep;
    logic [CW-1:0]                       w_end;
    logic [IW-1:0]                       w_idx;
    logic [AW-1:0]                       w_pos_a, w_cnt_a;
    logic [CW:0]                         w_mid;
    logic                                w_accept, w_out_free, w_full, w_empty;
    olist_pkg::t_op                      w_in_op;

    assign w_in_op    = olist_pkg::t_op'(i_in.op);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_keep     = (w_data[0] >= r_thr);
    assign w_end      = r_rem + r_kept - CW'(1);
    assign w_load     = w_do_ins ? r_val : w_data[0];

    assign w_pos_a = AW'(i_in.position) + AW'(1);
    assign w_cnt_a = AW'(r_count);
    assign w_mid   = ((CW + 1)'(r_count) + (CW + 1)'(1)) >> 1;

    always_comb begin
        case (w_in_op)
            olist_pkg::OP_PUSH_FRONT: w_idx = '0;
            olist_pkg::OP_POP_FRONT:  w_idx = '0;
            olist_pkg::OP_PUSH_BACK:  w_idx = IW'(r_count);
            olist_pkg::OP_POP_BACK:   w_idx = IW'(r_count - CW'(1));
            olist_pkg::OP_PUSH_MID:   w_idx = (r_count <= CW'(1)) ? '0 : IW'(w_mid);
            olist_pkg::OP_POP_MID:    w_idx = IW'(r_count >> 1);
            olist_pkg::OP_INSERT_AT:  w_idx = (w_pos_a > w_cnt_a) ? IW'(w_cnt_a) : IW'(w_pos_a);
            default:                  w_idx = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_kept      = r_kept;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_removed   = r_removed;
        w_do_ins    = 1'b0;
        w_do_rem    = 1'b0;
        w_do_filt   = 1'b0;
        i_in.ready  = (r_state == olist_pkg::S_IDLE);
        case (r_state)
            olist_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = olist_pkg::S_EXEC;
                end
            end
            olist_pkg::S_EXEC: begin
                case (r_op)
                    olist_pkg::OP_FILTER: begin
                        n_rem   = r_count;
                        n_kept  = '0;
                        n_state = olist_pkg::S_FILT;
                    end
                    olist_pkg::OP_POP_FRONT, olist_pkg::OP_POP_BACK,
                    olist_pkg::OP_POP_MID: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_state     = olist_pkg::S_IDLE;
                            if (w_empty) begin
                                n_status  = olist_pkg::ST_EMPTY;
                                n_removed = '0;
                            end else begin
                                w_do_rem  = 1'b1;
                                n_status  = olist_pkg::ST_DONE;
                                n_removed = w_data[r_idx];
                                n_count   = r_count - CW'(1);
                            end
                        end
                    end
                    default: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_state     = olist_pkg::S_IDLE;
                            n_removed   = '0;
                            if (w_full) begin
                                n_status = olist_pkg::ST_FULL;
                            end else begin
                                w_do_ins = 1'b1;
                                n_status = olist_pkg::ST_DONE;
                                n_count  = r_count + CW'(1);
                            end
                        end
                    end
                endcase
            end
            olist_pkg::S_FILT: begin
                if (r_rem != '0) begin
                    w_do_filt = 1'b1;
                    n_rem     = r_rem - CW'(1);
                    n_kept    = r_kept + CW'(w_keep);
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = olist_pkg::ST_DONE;
                    n_removed   = '0;
                    n_count     = r_kept;
                    n_state     = olist_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olist_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olist_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_kept    <= n_kept;
        r_status  <= n_status;
        r_removed <= n_removed;
        if (w_accept) begin
            r_op  <= w_in_op;
            r_val <= i_in.value;
            r_thr <= i_in.threshold;
            r_idx <= w_idx;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [olist_pkg::DATA_W-1:0] w_left;
        logic signed [olist_pkg::DATA_W-1:0] w_right;

        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[gi+1];
        end

        always_comb begin
            w_act[gi] = olist_pkg::ACT_HOLD;
            if (w_do_ins) begin
                if (IW'(gi) == r_idx) begin
                    w_act[gi] = olist_pkg::ACT_LOAD;
                end else if (IW'(gi) > r_idx) begin
                    w_act[gi] = olist_pkg::ACT_LEFT;
                end
            end else if (w_do_rem) begin
                if (IW'(gi) >= r_idx && gi < DEPTH - 1) begin
                    w_act[gi] = olist_pkg::ACT_RIGHT;
                end
            end else if (w_do_filt) begin
                if (CW'(gi) < w_end) begin
                    w_act[gi] = olist_pkg::ACT_RIGHT;
                end else if (CW'(gi) == w_end && w_keep) begin
                    w_act[gi] = olist_pkg::ACT_LOAD;
                end
            end
        end

        olist_cell u_cell (
            .i_clk   (i_clk),
            .i_act   (w_act[gi]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_load  (w_load),
            .o_data  (w_data[gi])
        );
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed;
    assign o_out.entry_count   = olist_pkg::ECOUNT_W'(r_count);

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == olist_pkg::S_EXEC))
        else $error("accepted beat did not start execution");

    a_filt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olist_pkg::S_FILT && r_rem != '0) |=> (r_rem == $past(r_rem) - CW'(1)))
        else $error("filter scan did not advance");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(DEPTH)) &&
        (r_state != olist_pkg::S_FILT || (r_rem + r_kept) <= r_count))
        else $error("entry count out of range");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == olist_pkg::ST_EMPTY) |-> (r_removed == '0 && r_count == '0))
        else $error("empty status with nonzero payload");

    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == olist_pkg::ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status while list not full");

endmodule

@@ tb/testbench.sv @@
// Testbench: directed and random commands into the ordered list engine, checked per result.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 1750;
    localparam int DRAIN_CYC = 40;
    localparam int DATA_W    = olist_pkg::DATA_W;
    localparam int POS_W     = olist_pkg::POS_W;
    localparam int ECOUNT_W  = olist_pkg::ECOUNT_W;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } t_mix;

    typedef struct {
        olist_pkg::t_op            op;
        logic signed [DATA_W-1:0]  value;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  threshold;
        bit                        calm;
    } t_list_cmd;

    typedef struct {
        olist_pkg::t_status        status;
        logic signed [DATA_W-1:0]  removed;
        logic [ECOUNT_W-1:0]       count;
    } t_list_reply;

    logic clk;
    logic rst_n;

    olist_in_if  cmd_ch();
    olist_out_if reply_ch();

    ordered_list_engine_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (reply_ch)
    );

    t_list_cmd                cmd_backlog[$];
    t_list_reply              reply_due[$];
    logic signed [DATA_W-1:0] list_model[$];

    bit          cmd_taken  = 1'b0;
    int unsigned send_gap   = 0;
    int unsigned hold_left  = 0;
    int unsigned ready_calm = 0;

    int n_total    = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_fail     = 0;
    int n_empty    = 0;
    int n_full     = 0;
    int n_filter   = 0;
    int n_at_depth = 0;

    // Apply one command to the shadow list and return the result it must produce.
    function automatic t_list_reply apply_cmd(t_list_cmd c);
        t_list_reply              r;
        int unsigned              n;
        int unsigned              idx;
        logic signed [DATA_W-1:0] kept[$];
        n         = list_model.size();
        r.status  = olist_pkg::ST_DONE;
        r.removed = '0;
        case (c.op)
            olist_pkg::OP_PUSH_FRONT, olist_pkg::OP_PUSH_BACK,
            olist_pkg::OP_PUSH_MID, olist_pkg::OP_INSERT_AT: begin
                if (n >= DEPTH) begin
                    r.status = olist_pkg::ST_FULL;
                end else begin
                    case (c.op)
                        olist_pkg::OP_PUSH_FRONT: idx = 0;
                        olist_pkg::OP_PUSH_BACK:  idx = n;
                        olist_pkg::OP_PUSH_MID:   idx = (n <= 1) ? 0 : (n + 1) / 2;
                        default: idx = (int'(c.position) + 1 > n) ? n : c.position + 1;
                    endcase
                    list_model.insert(idx, c.value);
                end
            end
            olist_pkg::OP_POP_FRONT, olist_pkg::OP_POP_BACK, olist_pkg::OP_POP_MID: begin
                if (n == 0) begin
                    r.status = olist_pkg::ST_EMPTY;
                end else begin
                    case (c.op)
                        olist_pkg::OP_POP_FRONT: idx = 0;
                        olist_pkg::OP_POP_BACK:  idx = n - 1;
                        default:                 idx = n / 2;
                    endcase
                    r.removed = list_model[idx];
                    list_model.delete(idx);
                end
            end
            default: begin
                foreach (list_model[i]) begin
                    if (list_model[i] >= c.threshold) kept.insert(kept.size(), list_model[i]);
                end
                list_model = kept;
            end
        endcase
        r.count = ECOUNT_W'(list_model.size());
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return INT_MIN;
                1:       return INT_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        if (r < 55) return $signed($urandom_range(0, 100)) - 50;
        return $urandom();
    endfunction

    function automatic olist_pkg::t_op pick_op(t_mix mix);
        int unsigned r;
        int unsigned fill_cut;
        int unsigned drain_cut;
        r         = $urandom_range(0, 99);
        fill_cut  = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 15 : 50;
        drain_cut = (mix == MIX_FILL) ? 95 : (mix == MIX_DRAIN) ? 90 : 88;
        if (r < fill_cut) begin
            case ($urandom_range(0, 3))
                0:       return olist_pkg::OP_PUSH_FRONT;
                1:       return olist_pkg::OP_PUSH_BACK;
                2:       return olist_pkg::OP_PUSH_MID;
                default: return olist_pkg::OP_INSERT_AT;
            endcase
        end
        if (r < drain_cut) begin
            case ($urandom_range(0, 2))
                0:       return olist_pkg::OP_POP_FRONT;
                1:       return olist_pkg::OP_POP_BACK;
                default: return olist_pkg::OP_POP_MID;
            endcase
        end
        return olist_pkg::OP_FILTER;
    endfunction

    task automatic queue_cmd(olist_pkg::t_op op, logic signed [DATA_W-1:0] value,
                             logic [POS_W-1:0] position, logic signed [DATA_W-1:0] threshold,
                             bit calm);
        t_list_cmd c;
        c.op        = op;
        c.value     = value;
        c.position  = position;
        c.threshold = threshold;
        c.calm      = calm;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Command side: advance on a beat or while idle, insert random gaps between beats.
    always @(negedge clk) begin
        t_list_cmd c;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_taken) begin
            if (send_gap > 0) begin
                cmd_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (cmd_backlog.size() != 0) begin
                c                  = cmd_backlog[0];
                cmd_backlog.delete(0);
                cmd_ch.op         <= c.op;
                cmd_ch.value      <= c.value;
                cmd_ch.position   <= c.position;
                cmd_ch.threshold  <= c.threshold;
                cmd_ch.valid      <= 1'b1;
                send_gap          <= c.calm ? 0 : pick_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: stall at random, with occasional long stretches held ready.
    always @(negedge clk) begin
        if (!rst_n) begin
            reply_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            reply_ch.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end else if (ready_calm > 0) begin
            reply_ch.ready <= 1'b1;
            ready_calm     <= ready_calm - 1;
        end else if ($urandom_range(0, 99) < 4) begin
            reply_ch.ready <= 1'b1;
            ready_calm     <= $urandom_range(40, 200);
        end else begin
            reply_ch.ready <= 1'b1;
            hold_left      <= pick_gap();
        end
    end

    always @(posedge clk) begin
        t_list_cmd   c;
        t_list_reply want;
        cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            c.op        = olist_pkg::t_op'(cmd_ch.op);
            c.value     = cmd_ch.value;
            c.position  = cmd_ch.position;
            c.threshold = cmd_ch.threshold;
            c.calm      = 1'b0;
            reply_due.insert(reply_due.size(), apply_cmd(c));
            n_accepted++;
            if (list_model.size() == DEPTH) n_at_depth++;
        end
        if (rst_n && reply_ch.valid && reply_ch.ready) begin
            if (reply_due.size() == 0) begin
                $error("result beat with no command outstanding");
                n_fail++;
            end else begin
                want = reply_due[0];
                reply_due.delete(0);
                n_checked++;
                if (want.status == olist_pkg::ST_EMPTY) n_empty++;
                if (want.status == olist_pkg::ST_FULL) n_full++;
                if (reply_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, reply_ch.status);
                    n_fail++;
                end
                if (reply_ch.removed_value !== want.removed) begin
                    $error("removed_value mismatch: expected %0d, actual %0d",
                           want.removed, reply_ch.removed_value);
                    n_fail++;
                end
                if (reply_ch.entry_count !== want.count) begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.count, reply_ch.entry_count);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        t_mix           mix;
        int unsigned    span;
        bit             calm;
        olist_pkg::t_op op;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = olist_pkg::OP_PUSH_FRONT;
        cmd_ch.value       = '0;
        cmd_ch.position    = '0;
        cmd_ch.threshold   = '0;
        reply_ch.ready     = 1'b0;

        queue_cmd(olist_pkg::OP_POP_FRONT,  '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_POP_BACK,   '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_POP_MID,    '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_INSERT_AT,  5,       4'd15, '0,      1'b0);
        queue_cmd(olist_pkg::OP_PUSH_MID,   7,       4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_PUSH_MID,   9,       4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_PUSH_FRONT, INT_MIN, 4'd0,  '0,      1'b1);
        queue_cmd(olist_pkg::OP_PUSH_BACK,  INT_MAX, 4'd0,  '0,      1'b1);
        queue_cmd(olist_pkg::OP_INSERT_AT,  -1,      4'd0,  '0,      1'b1);
        queue_cmd(olist_pkg::OP_INSERT_AT,  3,       4'd15, '0,      1'b0);
        queue_cmd(olist_pkg::OP_FILTER,     '0,      4'd0,  INT_MIN, 1'b0);
        queue_cmd(olist_pkg::OP_POP_MID,    '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_POP_FRONT,  '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_PUSH_BACK,  INT_MAX, 4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_FILTER,     '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_FILTER,     '0,      4'd0,  INT_MAX, 1'b0);
        queue_cmd(olist_pkg::OP_POP_BACK,   '0,      4'd0,  '0,      1'b0);
        queue_cmd(olist_pkg::OP_FILTER,     '0,      4'd0,  INT_MAX, 1'b0);
        queue_cmd(olist_pkg::OP_POP_FRONT,  '0,      4'd0,  '0,      1'b0);

        while (cmd_backlog.size() < N_RANDOM + 19) begin
            case ($urandom_range(0, 2))
                0:       mix = MIX_FILL;
                1:       mix = MIX_DRAIN;
                default: mix = MIX_ANY;
            endcase
            span = $urandom_range(20, 80);
            calm = ($urandom_range(0, 9) == 0);
            repeat (span) begin
                op = pick_op(mix);
                queue_cmd(op, pick_word(), POS_W'($urandom_range(0, 15)), pick_word(), calm);
                if (op == olist_pkg::OP_FILTER) n_filter++;
            end
        end
        n_total = cmd_backlog.size();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total) @(posedge clk);
        while (reply_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Ran %0d commands (%0d random filters), checked %0d results.",
                 n_total, n_filter, n_checked);
        $display("Empty pops: %0d, rejected inserts: %0d, commands leaving list full: %0d.",
                 n_empty, n_full, n_at_depth);
        if (n_fail == 0 && reply_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
